[hdl/nec_ir_pkg.sv]
// Shared types and constants for the NEC infrared pulse decoder.
`timescale 1ns / 1ps

package nec_ir_pkg;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_RECV = 2'd1,
        PH_HELD = 2'd2,
        PH_BAD  = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        REG_PREAMBLE_MIN = 3'd0,
        REG_PREAMBLE_MAX = 3'd1,
        REG_ZERO_MIN     = 3'd2,
        REG_ZERO_MAX     = 3'd3,
        REG_ONE_MIN      = 3'd4,
        REG_ONE_MAX      = 3'd5
    } reg_index_t;

    localparam logic [7:0] PREAMBLE_MIN_RST = 8'd195;
    localparam logic [7:0] PREAMBLE_MAX_RST = 8'd239;
    localparam logic [7:0] ZERO_MIN_RST     = 8'd16;
    localparam logic [7:0] ZERO_MAX_RST     = 8'd20;
    localparam logic [7:0] ONE_MIN_RST      = 8'd32;
    localparam logic [7:0] ONE_MAX_RST      = 8'd39;

    localparam int         FRAME_BITS       = 32;
    localparam logic [5:0] FRAME_BITS_CNT   = 6'd32;

    localparam logic       CMD_EDGE         = 1'b0;
    localparam logic       CMD_RELEASE      = 1'b1;

endpackage

[hdl/nec_ir_pulse_decoder.sv]
// NEC infrared pulse decoder: input stage, frame state update and result register.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction per measured
//   edge: cmd = 0 with interval and overflow, or cmd = 1 to release a held
//   frame. Every input transaction yields exactly one result transaction on
//   the output channel (out_valid / out_stall) carrying frame_ready, address,
//   command and rx_phase as they stand after that transaction.
//   Configuration writes go through cfg_valid / cfg_ready with cfg_index
//   0..5 selecting the timing window bounds; other indexes are dropped.
//   cfg_ready is always high.
// Path: an accepted transaction is registered in the input register, then in
//   the result register, where out_valid marks it.
// Throughput: one transaction per cycle while out_stall is low; window compare
//   and shift update are combinational between the input and result registers.
// Reset: waiting for preamble, bit count and shift register cleared, windows
//   at their default values, both pipeline registers empty.
// Stall: a stalled result holds in the result register; one more transaction
//   is taken into the input register, after which in_stall follows out_stall.
`timescale 1ns / 1ps

module nec_ir_pulse_decoder
    import nec_ir_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic       cmd,
    input  logic [7:0] interval,
    input  logic       overflow,

    output logic       out_valid,
    input  logic       out_stall,
    output logic       frame_ready,
    output logic [7:0] address,
    output logic [7:0] command,
    output logic [1:0] rx_phase,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic [7:0] preamble_min_reg;
    logic [7:0] preamble_max_reg;
    logic [7:0] zero_min_reg;
    logic [7:0] zero_max_reg;
    logic [7:0] one_min_reg;
    logic [7:0] one_max_reg;

    logic       s1_valid_reg;
    logic       s1_cmd_reg;
    logic [7:0] s1_interval_reg;
    logic       s1_overflow_reg;

    phase_t      phase_reg, phase_next;
    logic [5:0]  bit_count_reg, bit_count_next;
    logic [31:0] shift_code_reg, shift_code_next;

    logic        out_valid_reg;
    logic        frame_ready_reg, frame_ready_next;
    logic [7:0]  address_reg, address_next;
    logic [7:0]  command_reg, command_next;
    logic [1:0]  rx_phase_reg, rx_phase_next;

    logic        advance;
    logic        in_accept;
    logic        tick_ok;
    logic        hit_preamble;
    logic        hit_zero;
    logic        hit_one;
    logic [31:0] shifted;
    logic [5:0]  count_inc;
    logic        check_ok;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preamble_min_reg <= PREAMBLE_MIN_RST;
            preamble_max_reg <= PREAMBLE_MAX_RST;
            zero_min_reg     <= ZERO_MIN_RST;
            zero_max_reg     <= ZERO_MAX_RST;
            one_min_reg      <= ONE_MIN_RST;
            one_max_reg      <= ONE_MAX_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PREAMBLE_MIN: preamble_min_reg <= cfg_data;
                REG_PREAMBLE_MAX: preamble_max_reg <= cfg_data;
                REG_ZERO_MIN:     zero_min_reg     <= cfg_data;
                REG_ZERO_MAX:     zero_max_reg     <= cfg_data;
                REG_ONE_MIN:      one_min_reg      <= cfg_data;
                REG_ONE_MAX:      one_max_reg      <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Pipeline control
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance || !s1_valid_reg)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_cmd_reg      <= cmd;
            s1_interval_reg <= interval;
            s1_overflow_reg <= overflow;
        end
    end

    // Window compare and frame update
    assign tick_ok      = !s1_overflow_reg;
    assign hit_preamble = tick_ok && (s1_interval_reg >= preamble_min_reg)
                          && (s1_interval_reg <= preamble_max_reg);
    assign hit_zero     = tick_ok && (s1_interval_reg >= zero_min_reg)
                          && (s1_interval_reg <= zero_max_reg);
    assign hit_one      = tick_ok && (s1_interval_reg >= one_min_reg)
                          && (s1_interval_reg <= one_max_reg);
    assign shifted      = {shift_code_reg[FRAME_BITS-2:0], hit_one};
    assign count_inc    = bit_count_reg + 6'd1;
    assign check_ok     = (shifted[31:24] == ~shifted[23:16])
                          && (shifted[15:8] == ~shifted[7:0]);

    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        shift_code_next = shift_code_reg;
        if (s1_cmd_reg == CMD_RELEASE)
        begin
            if (phase_reg == PH_HELD || phase_reg == PH_BAD)
            begin
                phase_next = PH_WAIT;
            end
        end
        else
        begin
            case (phase_reg)
                PH_WAIT:
                begin
                    if (hit_preamble)
                    begin
                        bit_count_next = 6'd0;
                        phase_next     = PH_RECV;
                    end
                end
                PH_RECV:
                begin
                    shift_code_next = shifted;
                    if (!hit_one && !hit_zero)
                    begin
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        bit_count_next = count_inc;
                        if (count_inc == FRAME_BITS_CNT)
                        begin
                            phase_next = check_ok ? PH_HELD : PH_WAIT;
                        end
                    end
                end
                PH_HELD: ;
                default: phase_next = PH_WAIT;
            endcase
        end
    end

    always_comb
    begin
        frame_ready_next = (phase_next == PH_HELD);
        address_next     = frame_ready_next ? shift_code_next[31:24] : 8'd0;
        command_next     = frame_ready_next ? shift_code_next[15:8] : 8'd0;
        rx_phase_next    = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_WAIT;
            bit_count_reg  <= 6'd0;
            shift_code_reg <= 32'd0;
            out_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                phase_reg      <= phase_next;
                bit_count_reg  <= bit_count_next;
                shift_code_reg <= shift_code_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            frame_ready_reg <= frame_ready_next;
            address_reg     <= address_next;
            command_reg     <= command_next;
            rx_phase_reg    <= rx_phase_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_ready = frame_ready_reg;
    assign address     = address_reg;
    assign command     = command_reg;
    assign rx_phase    = rx_phase_reg;

    // Checks
    a_held_checked: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HELD |->
            (shift_code_reg[31:24] == ~shift_code_reg[23:16])
            && (shift_code_reg[15:8] == ~shift_code_reg[7:0]))
        else $error("held frame fails complement check");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_RECV |-> bit_count_reg < FRAME_BITS_CNT)
        else $error("bit count beyond frame length while receiving");

    a_ready_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (frame_ready_reg == (rx_phase_reg == PH_HELD)))
        else $error("frame_ready disagrees with rx_phase");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !frame_ready_reg |-> address_reg == 8'd0 && command_reg == 8'd0)
        else $error("result bytes non-zero without a held frame");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && s1_valid_reg) |=> $stable(phase_reg) && $stable(shift_code_reg))
        else $error("frame state changed without a transaction");

endmodule

[tb/nec_ir_frame_checker.sv]
// Checker for the NEC infrared pulse decoder: predicts each result transaction and compares it.
`timescale 1ns / 1ps

module nec_ir_frame_checker
    import nec_ir_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       cmd,
    input  logic [7:0] interval,
    input  logic       overflow,

    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       frame_ready,
    input  logic [7:0] address,
    input  logic [7:0] command,
    input  logic [1:0] rx_phase,

    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,

    output int         error_count,
    output int         pending_count,
    output int         result_count,
    output int         frame_count
);

    typedef struct packed {
        logic       ready;
        logic [7:0] address;
        logic [7:0] command;
        phase_t     phase;
    } decode_t;

    decode_t     pending_decodes[$];
    logic [7:0]  pre_lo;
    logic [7:0]  pre_hi;
    logic [7:0]  zero_lo;
    logic [7:0]  zero_hi;
    logic [7:0]  one_lo;
    logic [7:0]  one_hi;
    phase_t      model_phase;
    logic [5:0]  bit_count;
    logic [31:0] shift_code;

    function automatic logic in_window(input logic [7:0] t, input logic ok,
                                       input logic [7:0] lo, input logic [7:0] hi);
        return ok && t >= lo && t <= hi;
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < 40)
        begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
        error_count++;
    endtask

    task automatic decode_transaction(input logic c, input logic [7:0] t, input logic ov);
        logic    ok;
        decode_t r;
        ok = !ov;
        if (c == CMD_RELEASE)
        begin
            if (model_phase == PH_HELD || model_phase == PH_BAD)
            begin
                model_phase = PH_WAIT;
            end
        end
        else
        begin
            case (model_phase)
                PH_WAIT:
                begin
                    if (in_window(t, ok, pre_lo, pre_hi))
                    begin
                        bit_count   = '0;
                        model_phase = PH_RECV;
                    end
                end
                PH_RECV:
                begin
                    shift_code = {shift_code[30:0], 1'b0};
                    if (in_window(t, ok, one_lo, one_hi))
                    begin
                        shift_code[0] = 1'b1;
                    end
                    else if (!in_window(t, ok, zero_lo, zero_hi))
                    begin
                        model_phase = PH_WAIT;
                    end
                    if (model_phase == PH_RECV)
                    begin
                        bit_count = bit_count + 6'd1;
                        if (bit_count == FRAME_BITS_CNT)
                        begin
                            if (shift_code[31:24] == ~shift_code[23:16] &&
                                shift_code[15:8] == ~shift_code[7:0])
                            begin
                                model_phase = PH_HELD;
                                frame_count++;
                            end
                            else
                            begin
                                model_phase = PH_WAIT;
                            end
                        end
                    end
                end
                PH_HELD:
                begin
                end
                default:
                begin
                    model_phase = PH_WAIT;
                end
            endcase
        end
        r.ready   = (model_phase == PH_HELD);
        r.address = r.ready ? shift_code[31:24] : 8'h00;
        r.command = r.ready ? shift_code[15:8] : 8'h00;
        r.phase   = model_phase;
        pending_decodes.push_back(r);
    endtask

    task automatic check_result();
        decode_t e;
        result_count++;
        if (pending_decodes.size() == 0)
        begin
            report_mismatch("result transaction with nothing expected");
            return;
        end
        e = pending_decodes.pop_front();
        if (frame_ready !== e.ready)
        begin
            report_mismatch($sformatf("frame_ready got %b want %b", frame_ready, e.ready));
        end
        if (address !== e.address)
        begin
            report_mismatch($sformatf("address got %h want %h", address, e.address));
        end
        if (command !== e.command)
        begin
            report_mismatch($sformatf("command got %h want %h", command, e.command));
        end
        if (rx_phase !== e.phase)
        begin
            report_mismatch($sformatf("rx_phase got %0d want %0d", rx_phase, e.phase));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_lo      = PREAMBLE_MIN_RST;
            pre_hi      = PREAMBLE_MAX_RST;
            zero_lo     = ZERO_MIN_RST;
            zero_hi     = ZERO_MAX_RST;
            one_lo      = ONE_MIN_RST;
            one_hi      = ONE_MAX_RST;
            model_phase = PH_WAIT;
            bit_count   = '0;
            shift_code  = '0;
            pending_decodes.delete();
            error_count   = 0;
            pending_count = 0;
            result_count  = 0;
            frame_count   = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_result();
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PREAMBLE_MIN: pre_lo  = cfg_data;
                    REG_PREAMBLE_MAX: pre_hi  = cfg_data;
                    REG_ZERO_MIN:     zero_lo = cfg_data;
                    REG_ZERO_MAX:     zero_hi = cfg_data;
                    REG_ONE_MIN:      one_lo  = cfg_data;
                    REG_ONE_MAX:      one_hi  = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && !in_stall)
            begin
                decode_transaction(cmd, interval, overflow);
            end
            pending_count = pending_decodes.size();
        end
    end

endmodule

[tb/nec_ir_pulse_decoder_tb.sv]
// Testbench top for the NEC infrared pulse decoder: stimulus, idling patterns and verdict.
`timescale 1ns / 1ps

module nec_ir_pulse_decoder_tb;
    import nec_ir_pkg::*;

    localparam int ITEM_TARGET = 1900;
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 300000;

    // preamble, zero and one windows per setting, in register order
    localparam logic [0:5][0:5][7:0] WINDOW_SETTINGS = {
        8'd195, 8'd239, 8'd16,  8'd20,  8'd32,  8'd39,
        8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 8'd255,
        8'd100, 8'd100, 8'd1,   8'd127, 8'd128, 8'd254,
        8'd200, 8'd210, 8'd20,  8'd40,  8'd30,  8'd60,
        8'd150, 8'd180, 8'd255, 8'd0,   8'd40,  8'd50,
        8'd255, 8'd0,   8'd10,  8'd20,  8'd30,  8'd40
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid;
    logic       in_stall;
    logic       cmd;
    logic [7:0] interval;
    logic       overflow;
    logic       out_valid;
    logic       out_stall;
    logic       frame_ready;
    logic [7:0] address;
    logic [7:0] command;
    logic [1:0] rx_phase;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    int         error_count;
    int         pending_count;
    int         result_count;
    int         frame_count;
    int         cycle_count = 0;
    int         items_sent = 0;
    int         send_idle_pct = 19;
    int         recv_idle_pct = 70;
    logic       hold_req = 1'b0;
    logic [7:0] win [6];

    nec_ir_pulse_decoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .interval    (interval),
        .overflow    (overflow),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_ready (frame_ready),
        .address     (address),
        .command     (command),
        .rx_phase    (rx_phase),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    nec_ir_frame_checker frame_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .interval      (interval),
        .overflow      (overflow),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_ready   (frame_ready),
        .address       (address),
        .command       (command),
        .rx_phase      (rx_phase),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .pending_count (pending_count),
        .result_count  (result_count),
        .frame_count   (frame_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    out_stall = 1'b1;
                    @(negedge clk);
                end
            end
            out_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic logic hits(input logic [7:0] t, input logic [7:0] lo,
                                  input logic [7:0] hi);
        return t >= lo && t <= hi;
    endfunction

    function automatic logic [7:0] pick_in(input logic [7:0] lo, input logic [7:0] hi);
        if (lo <= hi)
        begin
            return 8'($urandom_range(hi, lo));
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pick_bit(input logic b);
        logic [7:0] t;
        int         n;
        if (b)
        begin
            return pick_in(win[REG_ONE_MIN], win[REG_ONE_MAX]);
        end
        t = pick_in(win[REG_ZERO_MIN], win[REG_ZERO_MAX]);
        for (n = 0; n < 8 && hits(t, win[REG_ONE_MIN], win[REG_ONE_MAX]); n++)
        begin
            t = pick_in(win[REG_ZERO_MIN], win[REG_ZERO_MAX]);
        end
        return t;
    endfunction

    function automatic logic [7:0] pick_bad();
        logic [7:0] t;
        int         n;
        t = 8'($urandom_range(255));
        for (n = 0; n < 8 && (hits(t, win[REG_ZERO_MIN], win[REG_ZERO_MAX]) ||
                              hits(t, win[REG_ONE_MIN], win[REG_ONE_MAX])); n++)
        begin
            t = 8'($urandom_range(255));
        end
        return t;
    endfunction

    task automatic drive_item(input logic c, input logic [7:0] t, input logic ov);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        cmd      = c;
        interval = t;
        overflow = ov;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending_count != 0)
        begin
            @(negedge clk);
        end
        repeat (3) @(negedge clk);
    endtask

    task automatic apply_setting(input int s);
        int r;
        drain();
        for (r = REG_PREAMBLE_MIN; r <= REG_ONE_MAX; r++)
        begin
            cfg_valid = 1'b1;
            cfg_index = reg_index_t'(r);
            cfg_data  = WINDOW_SETTINGS[s][r];
            do
                @(posedge clk);
            while (!cfg_ready);
            @(negedge clk);
            win[r] = WINDOW_SETTINGS[s][r];
        end
        cfg_valid = 1'b0;
    endtask

    task automatic send_frame(input logic [31:0] code);
        int i;
        int n;
        drive_item(CMD_EDGE, pick_in(win[REG_PREAMBLE_MIN], win[REG_PREAMBLE_MAX]), 1'b0);
        for (i = FRAME_BITS - 1; i >= 0; i--)
        begin
            drive_item(CMD_EDGE, pick_bit(code[i]), 1'b0);
        end
        items_sent += FRAME_BITS + 1;
        n = $urandom_range(2);
        repeat (n) drive_item(CMD_EDGE, 8'($urandom_range(255)), 1'($urandom_range(1)));
        items_sent += n;
        if ($urandom_range(3) != 0)
        begin
            drive_item(CMD_RELEASE, 8'($urandom_range(255)), 1'($urandom_range(1)));
            items_sent++;
        end
    endtask

    task automatic send_burst();
        int          kind;
        int          i;
        int          k;
        logic [7:0]  a;
        logic [7:0]  c;
        logic [31:0] code;
        kind = $urandom_range(99);
        a    = 8'($urandom_range(255));
        c    = 8'($urandom_range(255));
        code = {a, ~a, c, ~c};
        if (kind < 60)
        begin
            send_frame(code);
        end
        else if (kind < 72)
        begin
            send_frame(code ^ (32'h1 << $urandom_range(31)));
        end
        else if (kind < 86)
        begin
            drive_item(CMD_EDGE, pick_in(win[REG_PREAMBLE_MIN], win[REG_PREAMBLE_MAX]), 1'b0);
            k = $urandom_range(FRAME_BITS - 1);
            for (i = 0; i < k; i++)
            begin
                drive_item(CMD_EDGE, pick_bit(1'($urandom_range(1))), 1'b0);
            end
            if ($urandom_range(1))
            begin
                drive_item(CMD_EDGE, 8'($urandom_range(255)), 1'b1);
            end
            else
            begin
                drive_item(CMD_EDGE, pick_bad(), 1'b0);
            end
            items_sent += k + 2;
        end
        else
        begin
            k = $urandom_range(6, 1);
            for (i = 0; i < k; i++)
            begin
                drive_item(($urandom_range(7) == 0) ? CMD_RELEASE : CMD_EDGE,
                           8'($urandom_range(255)), ($urandom_range(3) == 0));
            end
            items_sent += k;
        end
    endtask

    initial
    begin
        int slot;
        int slot_end;
        int r;
        in_valid  = 1'b0;
        cmd       = CMD_EDGE;
        interval  = 8'h00;
        overflow  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_PREAMBLE_MIN;
        cfg_data  = 8'h00;
        for (r = REG_PREAMBLE_MIN; r <= REG_ONE_MAX; r++)
        begin
            win[r] = WINDOW_SETTINGS[0][r];
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset windows: boundaries, overflow, release and bad intervals
        drive_item(CMD_RELEASE, 8'h00, 1'b0);
        drive_item(CMD_EDGE, 8'd255, 1'b0);
        drive_item(CMD_EDGE, 8'd0, 1'b0);
        drive_item(CMD_EDGE, PREAMBLE_MIN_RST, 1'b1);
        drive_item(CMD_EDGE, PREAMBLE_MIN_RST - 8'd1, 1'b0);
        drive_item(CMD_EDGE, PREAMBLE_MAX_RST + 8'd1, 1'b0);
        drive_item(CMD_EDGE, PREAMBLE_MIN_RST, 1'b0);
        drive_item(CMD_EDGE, ZERO_MIN_RST, 1'b0);
        drive_item(CMD_EDGE, ZERO_MAX_RST, 1'b0);
        drive_item(CMD_EDGE, ONE_MIN_RST, 1'b0);
        drive_item(CMD_EDGE, ONE_MAX_RST, 1'b0);
        drive_item(CMD_EDGE, ZERO_MAX_RST + 8'd1, 1'b0);
        drive_item(CMD_EDGE, PREAMBLE_MAX_RST, 1'b0);
        drive_item(CMD_EDGE, ONE_MIN_RST, 1'b1);
        drive_item(CMD_EDGE, 8'd217, 1'b0);
        drive_item(CMD_EDGE, 8'd255, 1'b0);
        drive_item(CMD_RELEASE, 8'hff, 1'b1);
        items_sent += 17;

        slot = 0;
        while (items_sent < ITEM_TARGET)
        begin
            @(posedge clk);
            if (items_sent < ITEM_TARGET / 3)
            begin
                send_idle_pct = 19;
                recv_idle_pct = 70;
            end
            else if (items_sent < 2 * ITEM_TARGET / 3)
            begin
                send_idle_pct = 70;
                recv_idle_pct = 19;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            @(negedge clk);
            apply_setting(slot % 6);
            if (slot == 1 || slot == 9)
            begin
                @(posedge clk);
                hold_req = 1'b1;
                @(negedge clk);
            end
            slot_end = items_sent + ((slot % 6 >= 4) ? 40 : 120);
            while (items_sent < slot_end)
            begin
                send_burst();
            end
            slot++;
        end
        drain();

        $display("Covered %0d input transactions in %0d slots over six window settings",
                 result_count, slot);
        $display("and three idling patterns; %0d frames decoded and held, %0d mismatches.",
                 frame_count, error_count);
        if (error_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/nec_ir_pkg.sv
hdl/nec_ir_pulse_decoder.sv
tb/nec_ir_frame_checker.sv
tb/nec_ir_pulse_decoder_tb.sv
